/* design/implicit_list_heap_allocator_unit_assert.svh */
// Assertion macros for the heap allocator; they use the clk and rst of the including module.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

`define ILHA_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`define ILHA_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* design/ilha_pkg.sv */
// Types, constants and tag helper functions for the heap allocator.
`default_nettype none
package ilha_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int HEAP_WORDS = HEAP_BYTES / 8;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int TAG_W      = 17;
  localparam int REQ_W      = 17;
  localparam int ADDR_W     = 16;
  localparam int SUM_W      = ((IDX_W > TAG_W - 3) ? IDX_W : TAG_W - 3) + 1;
  localparam int GUARD_W    = IDX_W + 2;
  localparam int MIN_SPLIT  = 32;

  localparam logic [IDX_W-1:0]   EPI_IDX    = IDX_W'(HEAP_WORDS - 1);
  localparam logic [GUARD_W-1:0] GUARD_INIT = GUARD_W'(HEAP_WORDS + 2);

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;
  localparam status_t ST_BADFREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [1:0] policy_t;
  localparam policy_t POL_FIRST    = 2'd0;
  localparam policy_t POL_NEXT     = 2'd1;
  localparam policy_t POL_BEST     = 2'd2;
  localparam policy_t POL_BEST_ALT = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_NF_ADV, S_NF_TEST, S_FB_SCAN, S_A_TAKE, S_A_SPL2, S_A_SPL3, S_A_NB,
    S_F_SCAN, S_F_WF, S_M_NXT, S_M_PRV, S_M_PST, S_M_WR, S_M_WF, S_M_AFT, S_DONE
  } state_t;

  function automatic logic [TAG_W-1:0] tag_size(input logic [TAG_W-1:0] tag);
    return {tag[TAG_W-1:4], 4'b0000};
  endfunction

  function automatic logic [IDX_W-1:0] next_blk(input logic [IDX_W-1:0] idx,
                                                input logic [TAG_W-1:0] tag);
    logic [TAG_W-4:0] sz;
    logic [SUM_W-1:0] n;
    sz = {tag[TAG_W-1:4], 1'b0};
    n  = SUM_W'(idx) + SUM_W'(sz);
    if (idx >= EPI_IDX || sz == '0 || n > SUM_W'(EPI_IDX)) begin
      return EPI_IDX;
    end
    return n[IDX_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] foot_sum(input logic [IDX_W-1:0] idx,
                                               input logic [TAG_W-1:0] size);
    return SUM_W'(idx) + SUM_W'(size[TAG_W-1:3]) - SUM_W'(1);
  endfunction

  function automatic logic [TAG_W-1:0] init_word(input logic [IDX_W-1:0] idx);
    logic [TAG_W-1:0] free_tag;
    free_tag = TAG_W'(HEAP_BYTES - 16) | TAG_W'(2);
    if (idx == '0) begin
      return TAG_W'(3);
    end else if (idx == IDX_W'(1) || idx == EPI_IDX - IDX_W'(1)) begin
      return free_tag;
    end else if (idx == EPI_IDX) begin
      return TAG_W'(1);
    end
    return '0;
  endfunction

endpackage
`default_nettype wire

/* design/ilha_channels.sv */
// Channel interfaces for requests, results and the policy register.
`default_nettype none
interface ilha_req_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ilha_pkg::REQ_W-1:0]  request_bytes;
  logic [ilha_pkg::ADDR_W-1:0] payload_address;
  modport source (output valid, cmd, request_bytes, payload_address, input ready);
  modport sink (input valid, cmd, request_bytes, payload_address, output ready);
endinterface

interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ilha_pkg::ADDR_W-1:0] result_address;
  ilha_pkg::status_t           status;
  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

interface ilha_cfg_if;
  logic              valid;
  logic              ready;
  ilha_pkg::policy_t fit_policy;
  modport source (output valid, fit_policy, input ready);
  modport sink (input valid, fit_policy, output ready);
endinterface
`default_nettype wire

/* design/implicit_list_heap_allocator_unit.sv */
// Heap allocator over an implicit block list with boundary tags in a tag memory.
// After reset a clearing pass writes all 8192 words of the tag memory with the initial heap;
// no transaction is taken meanwhile. Allocate walks the block headers; the walk is set
// by the single read port of the tag memory. Free walks the blocks up to the target, then
// merges free neighbours. Zero requests and null, low or misaligned frees skip the walk.
// One transaction at a time; the result register lets the next request enter early.
`default_nettype none
`include "implicit_list_heap_allocator_unit_assert.svh"
module implicit_list_heap_allocator_unit (
  input  wire        clk,
  input  wire        rst,
  ilha_req_if.sink   req,
  ilha_rsp_if.source rsp,
  ilha_cfg_if.sink   cfg
);
  import ilha_pkg::*;

  logic [TAG_W-1:0] mem [HEAP_WORDS];
  logic [TAG_W-1:0] rdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [TAG_W-1:0] wdata;

  state_t state, state_next;
  logic             clearing;
  logic [IDX_W-1:0] clr_idx;
  policy_t          policy;
  logic [IDX_W-1:0] rover, rover_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [IDX_W-1:0] blk, blk_next;
  logic [IDX_W-1:0] base, base_next;
  logic [IDX_W-1:0] target, target_next;
  logic [IDX_W-1:0] best, best_next;
  logic [TAG_W-1:0] best_size, best_size_next;
  logic [TAG_W-1:0] asize, asize_next;
  logic [TAG_W-1:0] hsz, hsz_next;
  logic [TAG_W-1:0] msize, msize_next;
  logic             hprev, hprev_next;
  logic             mprev, mprev_next;
  logic [GUARD_W-1:0] guard, guard_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  status_t          res_status, res_status_next;
  logic             rsp_valid;
  logic [ADDR_W-1:0] rsp_addr;
  status_t          rsp_status;

  logic             accept, push;
  logic [TAG_W-1:0] wsize;
  logic             fit_here, nf_fail, fb_end, free_miss;
  logic [IDX_W-1:0] adv, nb, psz_idx;
  logic [TAG_W-4:0] psz;
  logic             prev_ok;
  logic [TAG_W-1:0] rem;
  logic [SUM_W-1:0] fidx, ffoot, hfoot, mfoot;
  logic [REQ_W:0]   round_sum;
  logic [GUARD_W-1:0] guard_dec;

  assign req.ready  = (state == S_IDLE) && !clearing;
  assign cfg.ready  = 1'b1;
  assign accept     = req.valid && req.ready;
  assign push       = (state == S_DONE) && (!rsp_valid || rsp.ready);
  assign rsp.valid  = rsp_valid;
  assign rsp.result_address = rsp_addr;
  assign rsp.status = rsp_status;

  assign wsize     = tag_size(rdata);
  assign fit_here  = (ptr != EPI_IDX) && !rdata[0] && (asize <= wsize);
  assign nb        = next_blk(ptr, rdata);
  assign adv       = (ptr == EPI_IDX) ? IDX_W'(1) : nb;
  assign guard_dec = guard - GUARD_W'(1);
  assign nf_fail   = !fit_here && ((ptr == base) || (guard_dec == '0));
  assign fb_end    = (ptr >= EPI_IDX);
  assign free_miss = (ptr >= EPI_IDX) ||
                     ((ptr == target) && !rdata[0]) ||
                     ((ptr != target) && ({1'b0, ptr} > ({1'b0, target} + (IDX_W + 1)'(1))));
  assign psz       = rdata[TAG_W-1:3];
  assign prev_ok   = (psz != '0) && ((TAG_W - 2)'(psz) < (TAG_W - 2)'(blk));
  assign psz_idx   = blk - IDX_W'(psz);
  assign rem       = hsz - asize;
  assign fidx      = SUM_W'(blk) + SUM_W'(asize[TAG_W-1:3]);
  assign ffoot     = fidx + SUM_W'(rem[TAG_W-1:3]) - SUM_W'(1);
  assign hfoot     = foot_sum(blk, hsz);
  assign mfoot     = foot_sum(base, msize);
  assign round_sum = (REQ_W + 1)'(req.request_bytes) + (REQ_W + 1)'(23);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == ptr_next) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[ptr_next];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_ALLOC) begin
            if (req.request_bytes == '0) begin
              state_next = S_DONE;
            end else if (policy == POL_NEXT) begin
              state_next = S_NF_ADV;
            end else begin
              state_next = S_FB_SCAN;
            end
          end else if (req.payload_address == '0 || req.payload_address < ADDR_W'(16) ||
                       req.payload_address[2:0] != 3'b000) begin
            state_next = S_DONE;
          end else begin
            state_next = S_F_SCAN;
          end
        end
      end
      S_NF_ADV:  state_next = S_NF_TEST;
      S_NF_TEST: begin
        if (fit_here) begin
          state_next = S_A_TAKE;
        end else if (nf_fail) begin
          state_next = S_DONE;
        end
      end
      S_FB_SCAN: begin
        if (fb_end) begin
          state_next = (best == '0) ? S_DONE : S_A_TAKE;
        end else if (fit_here && policy == POL_FIRST) begin
          state_next = S_A_TAKE;
        end
      end
      S_A_TAKE:  state_next = (wsize - asize >= TAG_W'(MIN_SPLIT)) ? S_A_SPL2 : S_A_NB;
      S_A_SPL2:  state_next = S_A_SPL3;
      S_A_SPL3:  state_next = S_DONE;
      S_A_NB:    state_next = S_DONE;
      S_F_SCAN: begin
        if (free_miss) begin
          state_next = S_DONE;
        end else if (ptr == target) begin
          state_next = S_F_WF;
        end
      end
      S_F_WF:    state_next = S_M_NXT;
      S_M_NXT:   state_next = hprev ? S_M_WR : S_M_PRV;
      S_M_PRV:   state_next = prev_ok ? S_M_PST : S_M_WR;
      S_M_PST:   state_next = S_M_WR;
      S_M_WR:    state_next = S_M_WF;
      S_M_WF:    state_next = S_M_AFT;
      S_M_AFT:   state_next = S_DONE;
      S_DONE:    state_next = push ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ptr_next        = ptr;
    blk_next        = blk;
    base_next       = base;
    target_next     = target;
    best_next       = best;
    best_size_next  = best_size;
    asize_next      = asize;
    hsz_next        = hsz;
    msize_next      = msize;
    hprev_next      = hprev;
    mprev_next      = mprev;
    guard_next      = guard;
    rover_next      = rover;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = ptr;
    wdata           = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_addr_next   = '0;
          res_status_next = ST_IGNORED;
          asize_next      = round_sum[REQ_W] ? '1 : {round_sum[REQ_W-1:4], 4'b0000};
          target_next     = IDX_W'(req.payload_address[ADDR_W-1:3]) - IDX_W'(1);
          best_next       = '0;
          best_size_next  = '0;
          guard_next      = GUARD_INIT;
          if (req.cmd == CMD_ALLOC) begin
            if (policy == POL_NEXT) begin
              base_next = (rover == '0) ? EPI_IDX : rover;
              ptr_next  = (rover == '0) ? EPI_IDX : rover;
            end else begin
              ptr_next = IDX_W'(1);
            end
          end else begin
            ptr_next = IDX_W'(1);
            if (req.payload_address != '0) begin
              res_status_next = ST_BADFREE;
            end
          end
        end
      end
      S_NF_ADV: ptr_next = adv;
      S_NF_TEST: begin
        if (fit_here) begin
          blk_next   = ptr;
          rover_next = ptr;
        end else if (nf_fail) begin
          rover_next      = base;
          res_status_next = ST_NOFIT;
        end else begin
          guard_next = guard_dec;
          ptr_next   = adv;
        end
      end
      S_FB_SCAN: begin
        if (fb_end) begin
          blk_next        = best;
          ptr_next        = best;
          res_status_next = ST_NOFIT;
        end else if (fit_here && policy == POL_FIRST) begin
          blk_next = ptr;
        end else begin
          if (fit_here && (best == '0 || best_size > wsize)) begin
            best_next      = ptr;
            best_size_next = wsize;
          end
          ptr_next = nb;
        end
      end
      S_A_TAKE: begin
        hsz_next        = wsize;
        hprev_next      = rdata[1];
        we              = 1'b1;
        waddr           = blk;
        res_status_next = ST_DONE;
        res_addr_next   = ADDR_W'({blk + IDX_W'(1), 3'b000});
        if (wsize - asize >= TAG_W'(MIN_SPLIT)) begin
          wdata = asize | TAG_W'({rdata[1], 1'b1});
        end else begin
          wdata    = wsize | TAG_W'({rdata[1], 1'b1});
          ptr_next = nb;
        end
      end
      S_A_SPL2: begin
        we    = 1'b1;
        waddr = fidx[IDX_W-1:0];
        wdata = rem | TAG_W'(2);
      end
      S_A_SPL3: begin
        we    = (ffoot < SUM_W'(HEAP_WORDS));
        waddr = ffoot[IDX_W-1:0];
        wdata = rem | TAG_W'(2);
      end
      S_A_NB: begin
        we    = 1'b1;
        wdata = rdata | TAG_W'(2);
      end
      S_F_SCAN: begin
        if (!free_miss) begin
          if (ptr == target) begin
            blk_next   = ptr;
            hsz_next   = wsize;
            hprev_next = rdata[1];
            we         = 1'b1;
            wdata      = wsize | TAG_W'({rdata[1], 1'b0});
          end else begin
            ptr_next = nb;
          end
        end
      end
      S_F_WF: begin
        we         = (hfoot < SUM_W'(HEAP_WORDS));
        waddr      = hfoot[IDX_W-1:0];
        wdata      = hsz | TAG_W'({hprev, 1'b0});
        ptr_next   = next_blk(blk, hsz);
        msize_next = hsz;
        base_next  = blk;
        mprev_next = hprev;
      end
      S_M_NXT: begin
        if (ptr < EPI_IDX && !rdata[0]) begin
          msize_next = msize + wsize;
        end
        if (!hprev) begin
          ptr_next = blk - IDX_W'(1);
        end
      end
      S_M_PRV: begin
        if (prev_ok) begin
          base_next  = psz_idx;
          msize_next = msize + wsize;
          ptr_next   = psz_idx;
        end
      end
      S_M_PST: mprev_next = rdata[1];
      S_M_WR: begin
        we    = 1'b1;
        waddr = base;
        wdata = msize | TAG_W'({mprev, 1'b0});
      end
      S_M_WF: begin
        we       = (mfoot < SUM_W'(HEAP_WORDS));
        waddr    = mfoot[IDX_W-1:0];
        wdata    = msize | TAG_W'({mprev, 1'b0});
        ptr_next = next_blk(base, msize);
      end
      S_M_AFT: begin
        we              = 1'b1;
        wdata           = rdata & ~TAG_W'(2);
        res_status_next = ST_DONE;
        if (rover > base && rover < ptr) begin
          rover_next = base;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = init_word(clr_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_idx   <= '0;
      policy    <= POL_NEXT;
      rover     <= EPI_IDX;
      rsp_valid <= 1'b0;
      ptr       <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      rover <= rover_next;
      if (clearing) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == EPI_IDX) begin
          clearing <= 1'b0;
        end
      end
      if (cfg.valid && cfg.ready) begin
        policy <= cfg.fit_policy;
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk        <= blk_next;
    base       <= base_next;
    target     <= target_next;
    best       <= best_next;
    best_size  <= best_size_next;
    asize      <= asize_next;
    hsz        <= hsz_next;
    msize      <= msize_next;
    hprev      <= hprev_next;
    mprev      <= mprev_next;
    guard      <= guard_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (push) begin
      rsp_addr   <= res_addr;
      rsp_status <= res_status;
    end
  end

  `ILHA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
  `ILHA_ASSERT_IMPLY(a_no_accept_in_clear, clearing, !req.ready, "ready during clearing pass")
  `ILHA_ASSERT_IMPLY(a_rover_nonzero, 1'b1, rover != '0, "rover points at prologue")
  `ILHA_ASSERT_IMPLY(a_prologue_kept, we && !clearing, waddr != '0, "prologue overwritten")

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the implicit list heap allocator unit.
`timescale 1ns / 100ps
module tb;
  import ilha_pkg::*;

  localparam int WORDS = HEAP_BYTES / 8;
  localparam int EPI = WORDS - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ilha_req_if req ();
  ilha_rsp_if rsp ();
  ilha_cfg_if cfg ();

  implicit_list_heap_allocator_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #5 clk = ~clk;

  int unsigned heap_tags[WORDS];
  int unsigned rover;
  policy_t policy;
  alloc_result_t pending_results[$];
  int unsigned live_blocks[$];
  int unsigned freed_blocks[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_done = 0;
  int n_nofit = 0;
  int n_badfree = 0;
  bit send_gaps = 1'b0;
  bit recv_gaps = 1'b0;
  bit recv_hold = 1'b0;

  function automatic int unsigned tag_bytes(int unsigned w);
    return w & ~32'hF;
  endfunction

  function automatic int unsigned following(int unsigned i);
    int unsigned sz;
    if (i >= EPI) begin
      return EPI;
    end
    sz = tag_bytes(heap_tags[i]) / 8;
    if (sz == 0 || i + sz > EPI) begin
      return EPI;
    end
    return i + sz;
  endfunction

  function automatic bit block_fits(int unsigned i, int unsigned need);
    return i < EPI && !heap_tags[i][0] && need <= tag_bytes(heap_tags[i]);
  endfunction

  function automatic void put_free(int unsigned i, int unsigned size, int unsigned prev);
    heap_tags[i] = size | prev;
    if (i + size / 8 - 1 < WORDS) begin
      heap_tags[i + size / 8 - 1] = size | prev;
    end
  endfunction

  function automatic int unsigned search_block(int unsigned need);
    int unsigned i, best, start, cur, guard;
    best = 0;
    if (policy == POL_NEXT) begin
      start = (rover > EPI || rover == 0) ? EPI : rover;
      cur = start;
      guard = WORDS + 2;
      do begin
        cur = (cur == EPI) ? 1 : following(cur);
        if (block_fits(cur, need)) begin
          rover = cur;
          return cur;
        end
        guard--;
      end while (cur != start && guard != 0);
      rover = start;
      return 0;
    end
    for (i = 1; i < EPI; i = following(i)) begin
      if (block_fits(i, need)) begin
        if (policy == POL_FIRST) begin
          return i;
        end
        if (best == 0 || tag_bytes(heap_tags[best]) > tag_bytes(heap_tags[i])) begin
          best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic void coalesce(int unsigned h);
    int unsigned start, size, prev, nb, psz, after;
    start = h;
    size = tag_bytes(heap_tags[h]);
    prev = heap_tags[h] & 2;
    nb = following(h);
    if (nb < EPI && !heap_tags[nb][0]) begin
      size += tag_bytes(heap_tags[nb]);
    end
    if (prev == 0) begin
      psz = tag_bytes(heap_tags[h - 1]) / 8;
      if (psz != 0 && psz < h) begin
        start = h - psz;
        size += psz * 8;
        prev = heap_tags[start] & 2;
      end
    end
    put_free(start, size, prev);
    after = following(start);
    heap_tags[after] &= ~32'h2;
    if (rover > start && rover < after) begin
      rover = start;
    end
  endfunction

  function automatic alloc_result_t predict_alloc(int unsigned nbytes);
    alloc_result_t r;
    int unsigned need, b, w, bs;
    r = '0;
    if (nbytes == 0) begin
      r.status = ST_IGNORED;
      return r;
    end
    need = ((nbytes + 23) / 16) * 16;
    b = search_block(need);
    if (b == 0) begin
      r.status = ST_NOFIT;
      return r;
    end
    w = heap_tags[b];
    bs = tag_bytes(w);
    if (bs - need >= MIN_SPLIT) begin
      heap_tags[b] = need | 1 | (w & 2);
      put_free(b + need / 8, bs - need, 2);
    end else begin
      heap_tags[b] = bs | 1 | (w & 2);
      heap_tags[following(b)] |= 2;
    end
    r.result_address = ADDR_W'(b * 8 + 8);
    r.status = ST_DONE;
    live_blocks.push_back(b * 8 + 8);
    return r;
  endfunction

  function automatic alloc_result_t predict_free(int unsigned pa);
    alloc_result_t r;
    int unsigned i, w;
    r = '0;
    r.status = ST_BADFREE;
    if (pa == 0) begin
      r.status = ST_IGNORED;
      return r;
    end
    if (pa < 16 || (pa & 7) != 0) begin
      return r;
    end
    for (i = 1; i < EPI; i = following(i)) begin
      if (i == pa / 8 - 1) begin
        w = heap_tags[i];
        if (!w[0]) begin
          return r;
        end
        put_free(i, tag_bytes(w), w & 2);
        coalesce(i);
        r.status = ST_DONE;
        return r;
      end
      if (i > pa / 8) begin
        break;
      end
    end
    return r;
  endfunction

  function automatic void reset_heap_model();
    foreach (heap_tags[i]) begin
      heap_tags[i] = 0;
    end
    heap_tags[0] = 3;
    put_free(1, HEAP_BYTES - 16, 2);
    heap_tags[EPI] = 1;
    rover = EPI;
    policy = POL_NEXT;
  endfunction

  task automatic send_item(logic cmd, int unsigned nbytes, int unsigned pa);
    alloc_result_t r;
    if (send_gaps && $urandom_range(99) < 17) begin
      req.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < 50);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.request_bytes <= REQ_W'(nbytes);
    req.payload_address <= ADDR_W'(pa);
    do begin
      @(posedge clk);
    end while (!req.ready);
    r = (cmd == CMD_ALLOC) ? predict_alloc(nbytes & 32'h1FFFF) : predict_free(pa & 32'hFFFF);
    if (cmd == CMD_FREE && r.status == ST_DONE) begin
      freed_blocks.push_back(pa);
    end
    pending_results.push_back(r);
    n_items++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_policy(policy_t p);
    drain();
    cfg.valid <= 1'b1;
    cfg.fit_policy <= p;
    do begin
      @(posedge clk);
    end while (!cfg.ready);
    policy = p;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live(int k);
    int unsigned pa;
    pa = live_blocks[k];
    live_blocks.delete(k);
    send_item(CMD_FREE, 0, pa);
  endtask

  task automatic random_item();
    int unsigned roll, pa, nbytes;
    roll = $urandom_range(99);
    if (live_blocks.size() > 0 && (roll < 40 || (live_blocks.size() > 120 && roll < 70))) begin
      free_live($urandom_range(live_blocks.size() - 1));
    end else if (roll >= 88) begin
      case ($urandom_range(4))
        0: pa = 0;
        1: pa = $urandom_range(16'hFFFF);
        2: pa = (live_blocks.size() > 0) ? live_blocks[0] + 8 * $urandom_range(1, 3) : 8;
        3: pa = (freed_blocks.size() > 0) ? freed_blocks[$urandom_range(freed_blocks.size() - 1)]
                                          : 16'hFFF8;
        default: pa = $urandom_range(16'hFFFF) | 1;
      endcase
      send_item(CMD_FREE, 0, pa);
    end else begin
      roll = $urandom_range(99);
      if (roll < 70) nbytes = $urandom_range(1, 120);
      else if (roll < 92) nbytes = $urandom_range(121, 2000);
      else if (roll < 97) nbytes = $urandom_range(2001, 65536);
      else if (roll < 98) nbytes = 0;
      else nbytes = $urandom_range(17'h1FFFF);
      send_item(CMD_ALLOC, nbytes, $urandom_range(16'hFFFF));
    end
  endtask

  task automatic test_edge_cases();
    int unsigned a, b;
    send_item(CMD_ALLOC, 0, 16'hFFFF);
    send_item(CMD_FREE, 17'h1FFFF, 0);
    send_item(CMD_ALLOC, 65536, 0);
    send_item(CMD_ALLOC, 65505, 0);
    send_item(CMD_ALLOC, 65512, 0);
    send_item(CMD_ALLOC, 1, 0);
    free_live(0);
    send_item(CMD_FREE, 0, 16);
    send_item(CMD_FREE, 0, 16'hFFFF);
    send_item(CMD_FREE, 0, 8);
    send_item(CMD_FREE, 0, 16'hFFF8);
    send_item(CMD_ALLOC, 1, 0);
    send_item(CMD_ALLOC, 24, 0);
    send_item(CMD_ALLOC, 40, 0);
    send_item(CMD_ALLOC, 100, 0);
    a = live_blocks[0];
    b = live_blocks[1];
    send_item(CMD_FREE, 0, b + 16);
    free_live(1);
    send_item(CMD_ALLOC, 8, 0);
    free_live(0);
    free_live(0);
    send_item(CMD_FREE, 0, a);
    free_live(0);
    free_live(0);
  endtask

  task automatic test_policy(policy_t p, int count);
    write_policy(p);
    repeat (count) random_item();
  endtask

  task automatic test_back_pressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (60) random_item();
    join
  endtask

  always @(posedge clk) begin
    if (rst || recv_hold) rsp.ready <= 1'b0;
    else rsp.ready <= !(recv_gaps && $urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("Result with no pending transaction: address %0h status %0d",
               rsp.result_address, rsp.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp.result_address !== e.result_address) begin
          $error("result_address: expected %0h, actual %0h", e.result_address,
                 rsp.result_address);
          errors++;
        end
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp.status);
          errors++;
        end
        case (e.status)
          ST_DONE: n_done++;
          ST_NOFIT: n_nofit++;
          ST_BADFREE: n_badfree++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_ALLOC;
    req.request_bytes = '0;
    req.payload_address = '0;
    cfg.valid = 1'b0;
    cfg.fit_policy = POL_NEXT;
    rsp.ready = 1'b0;
    reset_heap_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_policy(POL_FIRST, 300);
    test_policy(POL_BEST, 300);
    test_policy(POL_BEST_ALT, 200);
    test_policy(POL_NEXT, 300);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (200) random_item();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_back_pressure();
    test_policy(POL_FIRST, 165);
    drain();
    $display("Covered %0d transactions over all fit policies: %0d done, %0d no fit, %0d bad frees.",
             n_items, n_done, n_nofit, n_badfree);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
